FILE: sv/box_blur_3x3_edge_aware_core_defines.svh
// ----------------------------------------------------------------------------
// box blur 3x3 assertion macros
// Shared concurrent assertion forms used by the block's port checker.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AWARE_CORE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_CORE_DEFINES_SVH

// same-cycle implication, disabled while rst_n is low
`define BB3EA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bb3ea assertion failed");

// next-cycle implication, disabled while rst_n is low
`define BB3EA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bb3ea assertion failed");

`endif

FILE: sv/bb3ea_pkg.sv
// ----------------------------------------------------------------------------
// bb3ea_pkg
// Word types, register indexes and divide helpers for the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3ea_pkg;

    // input word: one pixel or one drain item
    typedef struct packed {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [7:0] blur_red;
        logic [7:0] blur_green;
        logic [7:0] blur_blue;
        logic       frame_end;
    } t_out_word;

    // input word kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index REG_IMAGE_WIDTH  = 8'd0;
    localparam t_cfg_index REG_IMAGE_HEIGHT = 8'd1;

    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 16;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

    // sum of up to nine 8-bit samples plus rounding
    localparam int SUM_W = 12;

    // neighbourhood size select
    typedef enum logic [1:0] {
        NSEL_4,
        NSEL_6,
        NSEL_9
    } t_nsel;

    // reciprocals for x/6 and x/9, exact for x below 4096
    localparam int                RECIP_W     = 14;
    localparam int                PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_6    = 14'd10923;
    localparam logic [RECIP_W-1:0] RECIP_9    = 14'd7282;
    localparam int                RECIP_SHIFT = 16;

    // rounded mean: (sum + n/2) / n for n of 4, 6 or 9
    function automatic logic [7:0] mean_div(input logic [SUM_W-1:0] sum, input t_nsel nsel);
        logic [SUM_W-1:0]  rsum;
        logic [PROD_W-1:0] prod;
        logic [7:0]        quo;
        rsum = '0;
        prod = '0;
        quo  = '0;
        case (nsel)
            NSEL_4: begin
                rsum = sum + SUM_W'(2);
                quo  = rsum[9:2];
            end
            NSEL_6: begin
                rsum = sum + SUM_W'(3);
                prod = PROD_W'(rsum) * PROD_W'(RECIP_6);
                quo  = prod[RECIP_SHIFT+7:RECIP_SHIFT];
            end
            NSEL_9: begin
                rsum = sum + SUM_W'(4);
                prod = PROD_W'(rsum) * PROD_W'(RECIP_9);
                quo  = prod[RECIP_SHIFT+7:RECIP_SHIFT];
            end
            default: begin
                quo = '0;
            end
        endcase
        return quo;
    endfunction

endpackage

FILE: sv/box_blur_3x3_edge_aware_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core
// Streaming 3x3 box blur of an RGB frame with edge-aware averaging.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock in raster order and returns, per pixel, the
// rounded per-channel mean of its in-image 3x3 neighbourhood (4 pixels at a
// corner, 6 on an edge, 9 inside). The block keeps one line memory of
// MAX_WIDTH entries holding the two previous rows side by side, read and
// written once per word, so the sustained rate is one word per clock as
// long as results are taken; a held result stalls the input only once the
// two internal stages behind it are full. A result moves from stage 1 to
// stage 2 to the output register, and results trail the pixel stream by
// one row plus one pixel: after the last pixel send image_width+1 drain
// words. The line memory needs no clearing pass after reset. Configuration
// writes are always taken, and a width or height write restarts the frame;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_core
    import bb3ea_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // pixel input
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_word               i_in_word,
    // result output
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_word              o_out_word,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  t_cfg_index             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int EW     = (WCNT_W > WIDTH_REG_W) ? WCNT_W : WIDTH_REG_W;
    localparam int IROW_W = HEIGHT_REG_W + 1;

    // window column masks (bit index is window column, 2 is newest)
    localparam logic [2:0] COLS_RIGHT_EDGE = 3'b011;
    localparam logic [2:0] COLS_ALL        = 3'b111;
    localparam logic [2:0] COLS_LEFT_EDGE  = 3'b110;

    // stage 1 word: one accepted item and its result control
    typedef struct packed {
        logic [23:0]      pix;
        logic [COL_W-1:0] addr;
        logic             emit;
        logic [2:0]       col_mask;
        logic [2:0]       row_mask;
        t_nsel            nsel;
        logic             last;
    } t_s1_word;

    // configuration registers
    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;

    // position counters
    logic [COL_W-1:0]        r_in_col, n_in_col;
    logic [IROW_W-1:0]       r_in_row, n_in_row;
    logic [COL_W-1:0]        r_out_col, n_out_col;
    logic [HEIGHT_REG_W-1:0] r_out_row, n_out_row;

    // line memory: upper row in the high half, middle row in the low half
    logic [47:0] r_line [MAX_WIDTH];
    logic [47:0] r_rd;

    // 3x3 window, [row: top, mid, bottom][col: oldest .. newest]
    logic [23:0] r_win [3][3];
    logic [23:0] win_next [3][3];

    // pipeline registers
    logic            r_s1_valid, n_s1_valid;
    t_s1_word        r_s1;
    t_s1_word        s1_load;
    logic            r_s2_valid, n_s2_valid;
    logic [SUM_W-1:0] r_s2_sum [3];
    t_nsel           r_s2_nsel;
    logic            r_s2_last;
    logic            r_out_valid, n_out_valid;
    t_out_word       r_out_word;

    logic [SUM_W-1:0] sum_tot [3];

    logic [EW-1:0]           w_ext;
    logic [EW-1:0]           eff_w;
    logic [HEIGHT_REG_W-1:0] eff_h;

    logic in_fire, cfg_fire, cfg_clear;
    logic is_drain, idle_drain, take;
    logic emit, col_zero, top_ok, bot_ok, out_col_last, out_row_last, in_col_last, last;
    logic cols3, rows3;
    logic s1_adv, s2_free, s2_adv, out_free;

    // handshakes
    assign out_free    = !r_out_valid || i_out_ready;
    assign s2_adv      = r_s2_valid && out_free;
    assign s2_free     = !r_s2_valid || out_free;
    assign s1_adv      = r_s1_valid && (!r_s1.emit || s2_free);
    assign o_in_ready  = !r_s1_valid || s1_adv;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;
    assign cfg_clear   = cfg_fire &&
                         (i_cfg_index == REG_IMAGE_WIDTH || i_cfg_index == REG_IMAGE_HEIGHT);

    // effective frame size
    always_comb begin
        w_ext = EW'(r_width);
        if (w_ext < EW'(2)) begin
            eff_w = EW'(2);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = w_ext;
        end
        eff_h = (r_height < HEIGHT_REG_W'(2)) ? HEIGHT_REG_W'(2) : r_height;
    end

    // per-item decisions from the position counters
    assign is_drain     = (i_in_word.kind == KIND_DRAIN);
    assign idle_drain   = is_drain && (r_in_row == '0) && (r_in_col == '0);
    assign take         = in_fire && !idle_drain;
    assign col_zero     = (r_in_col == '0);
    assign emit         = (r_in_row >= IROW_W'(2)) || ((r_in_row == IROW_W'(1)) && !col_zero);
    assign top_ok       = (r_out_row != '0);
    assign bot_ok       = (IROW_W'(r_out_row) + IROW_W'(1)) < IROW_W'(eff_h);
    assign out_row_last = !bot_ok;
    assign out_col_last = (EW'(r_out_col) + EW'(1)) >= eff_w;
    assign in_col_last  = (EW'(r_in_col) + EW'(1)) >= eff_w;
    assign last         = out_row_last && out_col_last;

    // stage 1 load word
    always_comb begin
        s1_load.pix  = is_drain ? 24'd0 : {i_in_word.red, i_in_word.green, i_in_word.blue};
        s1_load.addr = r_in_col;
        s1_load.emit = emit;
        s1_load.last = last;
        // right edge uses the window before the shift, i.e. new columns 0..1
        if (col_zero) begin
            s1_load.col_mask = COLS_RIGHT_EDGE;
        end else if (r_out_col != '0) begin
            s1_load.col_mask = COLS_ALL;
        end else begin
            s1_load.col_mask = COLS_LEFT_EDGE;
        end
        s1_load.row_mask = {bot_ok, 1'b1, top_ok};
        cols3 = (s1_load.col_mask == COLS_ALL);
        rows3 = top_ok && bot_ok;
        if (cols3 && rows3) begin
            s1_load.nsel = NSEL_9;
        end else if (cols3 || rows3) begin
            s1_load.nsel = NSEL_6;
        end else begin
            s1_load.nsel = NSEL_4;
        end
    end

    // counter next state
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (cfg_clear) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (take) begin
            if (emit && last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (emit) begin
                    if (out_col_last) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + HEIGHT_REG_W'(1);
                    end else begin
                        n_out_col = r_out_col + COL_W'(1);
                    end
                end
                if (in_col_last) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + IROW_W'(1);
                end else begin
                    n_in_col = r_in_col + COL_W'(1);
                end
            end
        end
    end

    // valid bits next state
    always_comb begin
        if (take) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
        if (s1_adv && r_s1.emit) begin
            n_s2_valid = 1'b1;
        end else if (s2_adv) begin
            n_s2_valid = 1'b0;
        end else begin
            n_s2_valid = r_s2_valid;
        end
        if (s2_adv) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_fire) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                    REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                    default: ;
                endcase
            end
            r_in_col    <= n_in_col;
            r_in_row    <= n_in_row;
            r_out_col   <= n_out_col;
            r_out_row   <= n_out_row;
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // line memory: read at accept, write back when the item leaves stage 1
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd <= r_line[r_in_col];
        end
        if (s1_adv) begin
            r_line[r_s1.addr] <= {r_rd[23:0], r_s1.pix};
        end
    end

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1 <= s1_load;
        end
    end

    // window shift: new column is upper, middle, incoming pixel
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r][0] = r_win[r][1];
            win_next[r][1] = r_win[r][2];
        end
        win_next[0][2] = r_rd[47:24];
        win_next[1][2] = r_rd[23:0];
        win_next[2][2] = r_s1.pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (s1_adv) begin
            r_win <= win_next;
        end
    end

    // masked neighbourhood sums, one row sum per window row then total
    always_comb begin
        logic [9:0] rsum [3];
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
                rsum[r] = '0;
                for (int c = 0; c < 3; c++) begin
                    if (r_s1.row_mask[r] && r_s1.col_mask[c]) begin
                        rsum[r] = rsum[r] + 10'(win_next[r][c][23-8*ch -: 8]);
                    end
                end
            end
            sum_tot[ch] = SUM_W'(rsum[0]) + SUM_W'(rsum[1]) + SUM_W'(rsum[2]);
        end
    end

    // stage 2 register
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.emit) begin
            r_s2_sum  <= sum_tot;
            r_s2_nsel <= r_s1.nsel;
            r_s2_last <= r_s1.last;
        end
    end

    // divide and output register
    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out_word.blur_red   <= mean_div(r_s2_sum[0], r_s2_nsel);
            r_out_word.blur_green <= mean_div(r_s2_sum[1], r_s2_nsel);
            r_out_word.blur_blue  <= mean_div(r_s2_sum[2], r_s2_nsel);
            r_out_word.frame_end  <= r_s2_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: sv/bb3ea_chk.sv
// ----------------------------------------------------------------------------
// bb3ea_chk
// Port-level checker for the 3x3 box blur, bound to the top level.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_aware_core_defines.svh"

module bb3ea_chk
    import bb3ea_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_in_word              i_in_word,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_word             o_out_word,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input t_cfg_index            i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // a stalled result word stays offered
    `BB3EA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // a stalled result word keeps its payload
    `BB3EA_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_word))

    // with the output side free the pipeline always takes a word
    `BB3EA_ASSERT_IMP(a_in_ready_free, i_clk, i_rst_n, !o_out_valid || i_out_ready, o_in_ready)

    // reset empties the output register
    `BB3EA_ASSERT_NXT(a_rst_empty, i_clk, 1'b1, !i_rst_n, !o_out_valid)

endmodule

bind box_blur_3x3_edge_aware_core bb3ea_chk u_bb3ea_chk (.*);

FILE: test/box_blur_3x3_edge_aware_core_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box blur 3x3 result checker
// Watches the pixel, result and register channels of the blur core, keeps its
// own line buffers, window and frame counters, works out the blurred word due
// for every accepted pixel word and compares each result word field by field.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_core_check
    import bb3ea_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel channel
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_word              i_in_word,
    // result channel
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_word             i_out_word,
    // register writes
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // status for the bench
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_results,
    output int                    o_frames
);

    // mirrored registers and frame state
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [23:0]             upper_line [MAX_WIDTH];
    logic [23:0]             middle_line [MAX_WIDTH];
    logic [23:0]             win [3][3];
    logic [11:0]             in_col;
    logic [11:0]             out_col;
    logic [16:0]             in_row;
    logic [16:0]             out_row;

    t_out_word expected_pixels [$];
    int        mismatch_count = 0;
    int        result_count   = 0;
    int        frame_count    = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] blur mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // rounded per-channel mean over window columns lo..2 of the in-image rows
    function automatic logic [23:0] window_mean(input int lo, input bit top_ok,
                                                input bit bot_ok);
        int          sum [3];
        int          n;
        logic [23:0] mean;
        sum  = '{0, 0, 0};
        n    = 0;
        mean = '0;
        for (int r = 0; r < 3; r++) begin
            if ((r == 0 && !top_ok) || (r == 2 && !bot_ok)) continue;
            for (int cc = lo; cc < 3; cc++) begin
                for (int ch = 0; ch < 3; ch++) sum[ch] += win[r][cc][23 - 8*ch -: 8];
                n++;
            end
        end
        for (int ch = 0; ch < 3; ch++) mean[23 - 8*ch -: 8] = 8'((sum[ch] + n / 2) / n);
        return mean;
    endfunction

    // advance the blur by one accepted word, returns 1 when a result is due
    function automatic bit blur_step(input t_in_word word, output t_out_word res);
        logic [12:0] wd;
        logic [16:0] ht;
        logic [23:0] pix;
        logic [23:0] mean;
        logic [23:0] column [3];
        logic [11:0] c;
        bit          emit;
        bit          top_ok;
        bit          bot_ok;
        res = '0;
        wd  = (width_reg < 12'd2) ? 13'd2 :
              (width_reg > MAX_WIDTH) ? 13'(MAX_WIDTH) : 13'(width_reg);
        ht  = (height_reg < 16'd2) ? 17'd2 : 17'(height_reg);
        c   = in_col;
        emit   = (in_row >= 17'd2) || (in_row == 17'd1 && c >= 12'd1);
        top_ok = out_row > 17'd0;
        bot_ok = (out_row + 17'd1) < ht;
        // drain word outside a frame does nothing
        if (word.kind == KIND_DRAIN && in_row == 17'd0 && in_col == 12'd0) return 1'b0;
        pix  = (word.kind == KIND_DRAIN) ? 24'd0 : {word.red, word.green, word.blue};
        mean = '0;
        // last column of a row: its window is the one before this shift
        if (emit && c == 12'd0) mean = window_mean(1, top_ok, bot_ok);
        // shift the new column in and roll the line buffers
        column[0] = upper_line[c];
        column[1] = middle_line[c];
        column[2] = pix;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
            win[r][2] = column[r];
        end
        upper_line[c]  = middle_line[c];
        middle_line[c] = pix;
        if (emit && c != 12'd0) mean = window_mean((out_col > 12'd0) ? 0 : 1, top_ok, bot_ok);
        if (emit) begin
            res.blur_red   = mean[23:16];
            res.blur_green = mean[15:8];
            res.blur_blue  = mean[7:0];
            res.frame_end  = (out_row + 17'd1 >= ht) && (13'(out_col) + 13'd1 >= wd);
            // frame closes: every counter back to the start
            if (res.frame_end) begin
                in_col  = '0;
                in_row  = '0;
                out_col = '0;
                out_row = '0;
                return 1'b1;
            end
            if (13'(out_col) + 13'd1 >= wd) begin
                out_col = '0;
                out_row++;
            end else begin
                out_col++;
            end
        end
        if (13'(in_col) + 13'd1 >= wd) begin
            in_col = '0;
            in_row++;
        end else begin
            in_col++;
        end
        return emit;
    endfunction

    // per-cycle monitor
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            for (int r = 0; r < 3; r++) begin
                for (int cc = 0; cc < 3; cc++) win[r][cc] = '0;
            end
            in_col  = '0;
            in_row  = '0;
            out_col = '0;
            out_row = '0;
            expected_pixels.delete();
        end else begin
            // result word against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result word with none outstanding", 1, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out_word.blur_red != want.blur_red)
                        report_mismatch("blur_red", i_out_word.blur_red, want.blur_red);
                    if (i_out_word.blur_green != want.blur_green)
                        report_mismatch("blur_green", i_out_word.blur_green, want.blur_green);
                    if (i_out_word.blur_blue != want.blur_blue)
                        report_mismatch("blur_blue", i_out_word.blur_blue, want.blur_blue);
                    if (i_out_word.frame_end != want.frame_end)
                        report_mismatch("frame_end", i_out_word.frame_end, want.frame_end);
                    result_count++;
                    if (want.frame_end) frame_count++;
                end
            end
            // width or height register write restarts the frame
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH: begin
                        width_reg = i_cfg_data[WIDTH_REG_W-1:0];
                        in_col  = '0;
                        in_row  = '0;
                        out_col = '0;
                        out_row = '0;
                    end
                    REG_IMAGE_HEIGHT: begin
                        height_reg = i_cfg_data[HEIGHT_REG_W-1:0];
                        in_col  = '0;
                        in_row  = '0;
                        out_col = '0;
                        out_row = '0;
                    end
                    default: begin
                    end
                endcase
            end
            // accepted pixel or drain word
            if (i_in_valid && i_in_ready) begin
                if (blur_step(i_in_word, want)) expected_pixels.push_back(want);
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_pixels.size();
        o_results    <= result_count;
        o_frames     <= frame_count;
    end

endmodule

FILE: test/box_blur_3x3_edge_aware_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box blur 3x3 core testbench
// Streams frames of random size and content through the blur core with random
// gaps and output stalls, covering edge sizes, drain words, extra pixels,
// aborted frames and clamped register values. The checker beside the core
// predicts every result word and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_core_tb;
    import bb3ea_pkg::*;

    localparam int MAX_WIDTH  = 2048;
    // far above the quiet stretch of a settle pause plus a run of stalls
    localparam int IDLE_LIMIT = 2000;
    // register index that selects nothing
    localparam t_cfg_index REG_UNUSED = 8'hFF;
    // words sent into the open frame at the clamped width
    localparam int WIDE_WORDS = 240;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_word              in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             out_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    t_cfg_index            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;
    int results;
    int frames;
    int words_sent   = 0;
    int settings     = 0;
    int stuck_cycles = 0;
    bit steady       = 1'b0;

    box_blur_3x3_edge_aware_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    box_blur_3x3_edge_aware_core_check #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results),
        .o_frames     (frames)
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    // result side stalls on about ten percent of cycles outside the steady phase
    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= 10);
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // channel value, biased toward the extremes
    function automatic logic [7:0] channel_level();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in_word make_word(input logic kind);
        t_in_word word;
        word.kind  = kind;
        word.red   = channel_level();
        word.green = channel_level();
        word.blue  = channel_level();
        return word;
    endfunction

    function automatic t_in_word pixel_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        t_in_word word;
        word.kind  = KIND_PIXEL;
        word.red   = r;
        word.green = g;
        word.blue  = b;
        return word;
    endfunction

    // one word on the pixel channel, with a random gap ahead of it outside the steady phase
    task automatic send_word(input t_in_word word);
        if (!steady) begin
            while ($urandom_range(99) < 10) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_word  <= word;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic write_reg(input t_cfg_index index, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every outstanding result plus the pipeline depth
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    // frame of w x h slots then w+1 drain slots; a cut between 0 and the full count stops early
    task automatic send_frame(input int w, input int h, input int cut, output int sent);
        int full;
        full = w * h + w + 1;
        sent = (cut > 0 && cut < full) ? cut : full;
        for (int k = 0; k < sent; k++) begin
            if (k < w * h) begin
                send_word(make_word(($urandom_range(99) < 3) ? KIND_DRAIN : KIND_PIXEL));
            end else begin
                send_word(make_word(($urandom_range(9) == 0) ? KIND_PIXEL : KIND_DRAIN));
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        int               w;
        int               h;
        int               sent;
        int               random_words;
        int               frame_total;
        logic [15:0]      wdata;
        logic [15:0]      hdata;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 2x2 from widths and heights below range, idle drain, extra pixel
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        write_reg(REG_IMAGE_HEIGHT, 16'd0);
        settings++;
        send_word(make_word(KIND_DRAIN));
        send_word(pixel_of(8'd255, 8'd0, 8'd1));
        send_word(pixel_of(8'd255, 8'd0, 8'd1));
        send_word(pixel_of(8'd0, 8'd255, 8'd0));
        send_word(pixel_of(8'd0, 8'd255, 8'd0));
        send_word(make_word(KIND_DRAIN));
        send_word(make_word(KIND_PIXEL));
        send_word(make_word(KIND_DRAIN));

        // 3x3 with corners, edges, center and a drain in the middle slot
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        settings++;
        for (int k = 0; k < 9; k++) begin
            if (k == 4) send_word(make_word(KIND_DRAIN));
            else send_word(pixel_of({8{k[0]}}, {8{k[1]}}, 8'(k * 37)));
        end
        for (int k = 0; k < 4; k++) send_word(make_word(KIND_DRAIN));

        // tallest frame with stray upper width bits, left open
        settle();
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        write_reg(REG_IMAGE_WIDTH, 16'hF003);
        settings++;
        for (int k = 0; k < 5; k++) send_word(pixel_of(8'hFF, 8'hFF, 8'hFF));

        // writes abort that frame; open a frame at the clamped width
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'h0FFF);
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        write_reg(REG_UNUSED, 16'h5A5A);
        settings++;
        send_frame(MAX_WIDTH, 2, WIDE_WORDS, sent);

        // random phases: new sizes, one to three frames, some cut short
        random_words = 0;
        while (random_words < 1000) begin
            steady = (random_words >= 400 && random_words < 600);
            settle();
            case ($urandom_range(9))
                0:       w = 2;
                1, 2:    w = $urandom_range(13, 80);
                default: w = $urandom_range(2, 12);
            endcase
            h     = $urandom_range(2, 8);
            wdata = {4'($urandom), 12'(w)};
            hdata = 16'(h);
            if (w == 2 && $urandom_range(1)) wdata = {4'($urandom), 11'd0, 1'($urandom)};
            if (h == 2 && $urandom_range(1)) hdata = 16'($urandom_range(1));
            write_reg(REG_IMAGE_WIDTH, wdata);
            write_reg(REG_IMAGE_HEIGHT, hdata);
            settings++;
            frame_total = $urandom_range(1, 3);
            for (int f = 0; f < frame_total; f++) begin
                if ($urandom_range(9) == 0) send_word(make_word(KIND_DRAIN));
                if ($urandom_range(9) == 0) begin
                    send_frame(w, h, $urandom_range(1, w * h + w), sent);
                    random_words += sent;
                    break;
                end
                send_frame(w, h, 0, sent);
                random_words += sent;
            end
        end
        steady = 1'b0;

        settle();
        repeat (16) @(posedge clk);
        $display("run covered %0d words over %0d size settings: %0d blurred pixels checked,",
                 words_sent, settings, results);
        $display("%0d frames closed, plus an aborted frame at the clamped width of %0d",
                 frames, MAX_WIDTH);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: box_blur_3x3_edge_aware_core.f
+incdir+sv
sv/bb3ea_pkg.sv
sv/box_blur_3x3_edge_aware_core.sv
sv/bb3ea_chk.sv
test/box_blur_3x3_edge_aware_core_check.sv
test/box_blur_3x3_edge_aware_core_tb.sv
